// ----- design/dwc_pkg.sv -----
// Shared types and constants for the nibble-packed depthwise conv engine.
// No dependencies; used by dwc_lane and depthwise_conv_u4_mac_requant.
`default_nettype none

package dwc_pkg;

  localparam int unsigned CHANNELS_DEF = 64;
  localparam int unsigned PAIR_W       = 5;
  localparam int unsigned MAX_PAIRS    = 1 << PAIR_W;
  localparam int unsigned NIB_W        = 4;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned SHIFT_W      = 6;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TAP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACT_ZP = 3'd0,
    REG_WT_ZP  = 3'd1,
    REG_OUT_ZP = 3'd2,
    REG_MULT   = 3'd3,
    REG_SHIFT  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_MUL,
    S_OUT
  } state_e;

  // per-cycle strobes from the sequencer to both lanes
  typedef struct packed {
    logic load;
    logic rd;
    logic mac;
    logic mul;
    logic first;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- design/dwc_lane.sv -----
// One channel lane: bias and accumulator memories, 4-bit MAC and requantizer.
// Depends on dwc_pkg.
`default_nettype none

module dwc_lane #(
  parameter int unsigned DEPTH = dwc_pkg::MAX_PAIRS,
  parameter int unsigned AW    = 5
) (
  input  wire logic                                  clk_i,
  input  wire dwc_pkg::lane_ctrl_t                   ctrl_i,
  input  wire logic [AW-1:0]                         addr_i,
  input  wire logic [dwc_pkg::NIB_W-1:0]             act_i,
  input  wire logic [dwc_pkg::NIB_W-1:0]             wt_i,
  input  wire logic [dwc_pkg::NIB_W-1:0]             act_zp_i,
  input  wire logic [dwc_pkg::NIB_W-1:0]             wt_zp_i,
  input  wire logic [dwc_pkg::NIB_W-1:0]             out_zp_i,
  input  wire logic signed [dwc_pkg::ACC_W-1:0]      bias_i,
  input  wire logic signed [dwc_pkg::ACC_W-1:0]      mult_i,
  input  wire logic signed [dwc_pkg::SHIFT_W-1:0]    shift_i,
  output logic [dwc_pkg::NIB_W-1:0]                  nib_o
);

  logic signed [dwc_pkg::ACC_W-1:0]   bias_mem [DEPTH];
  logic signed [dwc_pkg::ACC_W-1:0]   acc_mem  [DEPTH];

  logic signed [dwc_pkg::ACC_W-1:0]   bias_rd_q, acc_rd_q;
  logic [dwc_pkg::NIB_W-1:0]          act_q, wt_q;
  logic signed [dwc_pkg::ACC_W-1:0]   t_q, t_d;
  logic signed [2*dwc_pkg::ACC_W-1:0] prod_q;

  logic signed [dwc_pkg::NIB_W:0]     dw, da;
  logic signed [2*dwc_pkg::NIB_W+1:0] term;
  logic signed [dwc_pkg::ACC_W-1:0]   base, sum;
  logic [dwc_pkg::SHIFT_W-1:0]        left;
  logic [dwc_pkg::SHIFT_W-2:0]        rs;
  logic signed [dwc_pkg::ACC_W-1:0]   hi, r;
  logic signed [dwc_pkg::ACC_W:0]     y;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      bias_mem[addr_i] <= bias_i;
    end
    if (ctrl_i.rd) begin
      bias_rd_q <= bias_mem[addr_i];
      acc_rd_q  <= acc_mem[addr_i];
      act_q     <= act_i;
      wt_q      <= wt_i;
    end
    if (ctrl_i.mac) begin
      acc_mem[addr_i] <= sum;
      t_q             <= t_d;
    end
    if (ctrl_i.mul) begin
      prod_q <= t_q * mult_i;
    end
  end

  // MAC stage, then pre-multiply left shift
  always_comb begin
    dw   = $signed({1'b0, wt_q})  - $signed({1'b0, wt_zp_i});
    da   = $signed({1'b0, act_q}) - $signed({1'b0, act_zp_i});
    term = dw * da;
    base = ctrl_i.first ? bias_rd_q : acc_rd_q;
    sum  = base + dwc_pkg::ACC_W'(term);
    left = shift_i[dwc_pkg::SHIFT_W-1] ? dwc_pkg::SHIFT_W'(-shift_i) : '0;
    // a shift of 32 clears the word
    t_d  = left[dwc_pkg::SHIFT_W-1] ? '0 : (sum <<< left[dwc_pkg::SHIFT_W-2:0]);
  end

  // high word, right shift, offset and clamp to 0..15
  always_comb begin
    hi = prod_q[2*dwc_pkg::ACC_W-1:dwc_pkg::ACC_W];
    rs = shift_i[dwc_pkg::SHIFT_W-1] ? '0 : shift_i[dwc_pkg::SHIFT_W-2:0];
    r  = hi >>> rs;
    y  = {r[dwc_pkg::ACC_W-1], r} + $signed({{(dwc_pkg::ACC_W-dwc_pkg::NIB_W+1){1'b0}}, out_zp_i});
    if (y[dwc_pkg::ACC_W]) begin
      nib_o = '0;
    end else if (y[dwc_pkg::ACC_W-1:dwc_pkg::NIB_W] != '0) begin
      nib_o = '1;
    end else begin
      nib_o = y[dwc_pkg::NIB_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/depthwise_conv_u4_mac_requant.sv -----
// Result: a tap with last_tap set passes the MAC, MUL and OUT states and the output
// register before it shows; the strobe is one cycle wide and the receiver cannot stall it.
// Pacing: a bias load does not raise busy; a tap holds busy through MAC and a last tap
// through MAC / 32x32 multiply / requant (MAC, MUL, OUT), run by both lanes in step.
// Reset (rst_ni low, async): sequencer idle, control regs at reset values; rest undefined.
`default_nettype none

module depthwise_conv_u4_mac_requant #(
  parameter int unsigned CHANNELS = dwc_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // command request
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 cmd_i,
  input  wire logic [dwc_pkg::PAIR_W-1:0]           channel_pair_i,
  input  wire logic [7:0]                           act_byte_i,
  input  wire logic [7:0]                           wt_byte_i,
  input  wire logic                                 first_tap_i,
  input  wire logic                                 last_tap_i,
  input  wire logic signed [dwc_pkg::ACC_W-1:0]     bias_even_i,
  input  wire logic signed [dwc_pkg::ACC_W-1:0]     bias_odd_i,
  // configuration write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [dwc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [dwc_pkg::ACC_W-1:0]            cfg_data_i,
  // result strobe
  output logic                                      out_valid_o,
  output logic [7:0]                                out_byte_o,
  output logic [dwc_pkg::PAIR_W-1:0]                out_channel_pair_o
);

  // pairs beyond the 5-bit pair index can never be addressed
  localparam int unsigned PAIRS = CHANNELS / 2;
  localparam int unsigned DEPTH = (PAIRS < dwc_pkg::MAX_PAIRS) ? PAIRS : dwc_pkg::MAX_PAIRS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dwc_pkg::state_e      state_q, state_d;
  dwc_pkg::lane_ctrl_t  ctrl;

  logic [dwc_pkg::NIB_W-1:0]          act_zp_q, wt_zp_q, out_zp_q;
  logic signed [dwc_pkg::ACC_W-1:0]   mult_q;
  logic signed [dwc_pkg::SHIFT_W-1:0] shift_q;

  logic [dwc_pkg::PAIR_W-1:0] pair_q;
  logic                       first_q, last_q;
  logic                       accept, in_range;
  logic [AW-1:0]              addr;
  logic [dwc_pkg::NIB_W-1:0]  nib_even, nib_odd;

  logic                       out_valid_q;
  logic [7:0]                 out_byte_q;
  logic [dwc_pkg::PAIR_W-1:0] out_pair_q;

  assign busy        = (state_q != dwc_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign in_range    = (32'(channel_pair_i) < DEPTH);
  assign cfg_ready_o = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_zp_q <= '0;
      wt_zp_q  <= '0;
      out_zp_q <= '0;
      mult_q   <= 32'sh4000_0000;
      shift_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dwc_pkg::cfg_reg_e'(cfg_index_i))
        dwc_pkg::REG_ACT_ZP: act_zp_q <= cfg_data_i[dwc_pkg::NIB_W-1:0];
        dwc_pkg::REG_WT_ZP:  wt_zp_q  <= cfg_data_i[dwc_pkg::NIB_W-1:0];
        dwc_pkg::REG_OUT_ZP: out_zp_q <= cfg_data_i[dwc_pkg::NIB_W-1:0];
        dwc_pkg::REG_MULT:   mult_q   <= cfg_data_i;
        dwc_pkg::REG_SHIFT:  shift_q  <= cfg_data_i[dwc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwc_pkg::S_IDLE;
      first_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.rd) begin
        first_q <= first_tap_i;
        last_q  <= last_tap_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.rd) begin
      pair_q <= channel_pair_i;
    end
  end

  // sequencer: loads finish at the request edge, taps run MAC (+ MUL, OUT)
  always_comb begin
    state_d    = state_q;
    ctrl       = '0;
    ctrl.first = first_q;
    case (state_q)
      dwc_pkg::S_IDLE: begin
        ctrl.load = accept && in_range && (cmd_i == dwc_pkg::CMD_LOAD);
        ctrl.rd   = accept && in_range && (cmd_i == dwc_pkg::CMD_TAP);
        if (ctrl.rd) begin
          state_d = dwc_pkg::S_MAC;
        end
      end
      dwc_pkg::S_MAC: begin
        ctrl.mac = 1'b1;
        state_d  = last_q ? dwc_pkg::S_MUL : dwc_pkg::S_IDLE;
      end
      dwc_pkg::S_MUL: begin
        ctrl.mul = 1'b1;
        state_d  = dwc_pkg::S_OUT;
      end
      dwc_pkg::S_OUT: begin
        state_d = dwc_pkg::S_IDLE;
      end
      default: begin
        state_d = dwc_pkg::S_IDLE;
      end
    endcase
  end

  assign addr = (state_q == dwc_pkg::S_IDLE) ? channel_pair_i[AW-1:0] : pair_q[AW-1:0];

  dwc_lane #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_lane_even (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .addr_i   (addr),
    .act_i    (act_byte_i[3:0]),
    .wt_i     (wt_byte_i[3:0]),
    .act_zp_i (act_zp_q),
    .wt_zp_i  (wt_zp_q),
    .out_zp_i (out_zp_q),
    .bias_i   (bias_even_i),
    .mult_i   (mult_q),
    .shift_i  (shift_q),
    .nib_o    (nib_even)
  );

  dwc_lane #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_lane_odd (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .addr_i   (addr),
    .act_i    (act_byte_i[7:4]),
    .wt_i     (wt_byte_i[7:4]),
    .act_zp_i (act_zp_q),
    .wt_zp_i  (wt_zp_q),
    .out_zp_i (out_zp_q),
    .bias_i   (bias_odd_i),
    .mult_i   (mult_q),
    .shift_i  (shift_q),
    .nib_o    (nib_odd)
  );

  // merge: pack both lanes into the output register, even in the low nibble
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == dwc_pkg::S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dwc_pkg::S_OUT) begin
      out_byte_q <= {nib_odd, nib_even};
      out_pair_q <= pair_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign out_channel_pair_o = out_pair_q;

`ifndef SYNTHESIS
  a_last_tap_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_range && cmd_i == dwc_pkg::CMD_TAP && last_tap_i) |-> ##4 out_valid_o)
    else $error("last tap did not produce a result after 4 cycles");

  a_mid_tap_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dwc_pkg::S_MAC && !last_q) |=> (state_q == dwc_pkg::S_IDLE) ##1 !out_valid_o)
    else $error("non-last tap produced a result or stayed busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (!in_range || cmd_i == dwc_pkg::CMD_LOAD)) |=> !busy)
    else $error("load or out-of-range request left the block busy");
`endif

endmodule

`default_nettype wire

// ----- sim/dwc_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for depthwise_conv_u4_mac_requant: keeps its own bias, accumulator and
// register state, predicts every packed output byte and compares it with the block.
// Depends on dwc_pkg for widths, command codes and register indexes.
module dwc_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic                          cmd_i,
  input  wire logic [dwc_pkg::PAIR_W-1:0]    channel_pair_i,
  input  wire logic [7:0]                    act_byte_i,
  input  wire logic [7:0]                    wt_byte_i,
  input  wire logic                          first_tap_i,
  input  wire logic                          last_tap_i,
  input  wire logic [dwc_pkg::ACC_W-1:0]     bias_even_i,
  input  wire logic [dwc_pkg::ACC_W-1:0]     bias_odd_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [dwc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dwc_pkg::ACC_W-1:0]     cfg_data_i,
  input  wire logic                          out_valid_i,
  input  wire logic [7:0]                    out_byte_i,
  input  wire logic [dwc_pkg::PAIR_W-1:0]    out_pair_i,
  output int unsigned                        fail_count_o = 0,
  output int unsigned                        pending_o = 0
);

  localparam int unsigned NPAIRS = dwc_pkg::CHANNELS_DEF / 2;

  typedef struct packed {
    logic [7:0]                 data;
    logic [dwc_pkg::PAIR_W-1:0] pair;
  } packed_out_t;

  logic [dwc_pkg::ACC_W-1:0]          bias_mem [dwc_pkg::CHANNELS_DEF];
  logic [dwc_pkg::ACC_W-1:0]          acc_mem  [dwc_pkg::CHANNELS_DEF];
  logic [dwc_pkg::NIB_W-1:0]          act_zp;
  logic [dwc_pkg::NIB_W-1:0]          wt_zp;
  logic [dwc_pkg::NIB_W-1:0]          out_zp;
  logic signed [dwc_pkg::ACC_W-1:0]   mult;
  logic signed [dwc_pkg::SHIFT_W-1:0] shift;
  packed_out_t                        out_q [$];
  packed_out_t                        head;
  logic [dwc_pkg::ACC_W-1:0]          sum_even;
  logic [dwc_pkg::ACC_W-1:0]          sum_odd;
  int unsigned                        ch_even;

  // one product term of a tap, offsets removed, wrapped to the accumulator width
  function automatic logic [dwc_pkg::ACC_W-1:0] tap_product(
      input logic [dwc_pkg::NIB_W-1:0] w,
      input logic [dwc_pkg::NIB_W-1:0] a);
    int dw;
    int da;
    logic [dwc_pkg::ACC_W-1:0] r;
    dw = int'(w) - int'(wt_zp);
    da = int'(a) - int'(act_zp);
    r  = dw * da;
    return r;
  endfunction

  // left shift (truncating), high word of the product, floor right shift, offset, clamp
  function automatic logic [dwc_pkg::NIB_W-1:0] requant_nibble(
      input logic [dwc_pkg::ACC_W-1:0] sum);
    logic [dwc_pkg::ACC_W-1:0] t;
    longint                    y;
    int                        sh;
    sh = int'(shift);
    t  = sum;
    if (sh < 0) t = (-sh >= dwc_pkg::ACC_W) ? '0 : sum << (-sh);
    y = longint'($signed(t)) * longint'(mult);
    y = y >>> dwc_pkg::ACC_W;
    if (sh > 0) y = y >>> sh;
    y = y + longint'(out_zp);
    if (y < 0) return '0;
    if (y > longint'({dwc_pkg::NIB_W{1'b1}})) return {dwc_pkg::NIB_W{1'b1}};
    return y[dwc_pkg::NIB_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_zp       = '0;
      wt_zp        = '0;
      out_zp       = '0;
      mult         = 32'sh4000_0000;
      shift        = '0;
      fail_count_o = 0;
      out_q.delete();
    end else begin
      // results first: anything on the strobe now belongs to an older request
      if (out_valid_i) begin
        if (out_q.size() == 0) begin
          note_failure($sformatf("unexpected output byte %02h pair %0d",
                                 out_byte_i, out_pair_i));
        end else begin
          head = out_q.pop_front();
          if (out_byte_i !== head.data || out_pair_i !== head.pair)
            note_failure($sformatf("output mismatch: byte exp %02h got %02h, pair exp %0d got %0d",
                                   head.data, out_byte_i, head.pair, out_pair_i));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (dwc_pkg::cfg_reg_e'(cfg_index_i))
          dwc_pkg::REG_ACT_ZP: act_zp = cfg_data_i[dwc_pkg::NIB_W-1:0];
          dwc_pkg::REG_WT_ZP:  wt_zp  = cfg_data_i[dwc_pkg::NIB_W-1:0];
          dwc_pkg::REG_OUT_ZP: out_zp = cfg_data_i[dwc_pkg::NIB_W-1:0];
          dwc_pkg::REG_MULT:   mult   = cfg_data_i;
          dwc_pkg::REG_SHIFT:  shift  = cfg_data_i[dwc_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i && channel_pair_i < NPAIRS) begin
        ch_even = 2 * channel_pair_i;
        if (cmd_i == dwc_pkg::CMD_LOAD) begin
          bias_mem[ch_even]     = bias_even_i;
          bias_mem[ch_even + 1] = bias_odd_i;
        end else begin
          sum_even = first_tap_i ? bias_mem[ch_even]     : acc_mem[ch_even];
          sum_odd  = first_tap_i ? bias_mem[ch_even + 1] : acc_mem[ch_even + 1];
          sum_even += tap_product(wt_byte_i[3:0], act_byte_i[3:0]);
          sum_odd  += tap_product(wt_byte_i[7:4], act_byte_i[7:4]);
          acc_mem[ch_even]     = sum_even;
          acc_mem[ch_even + 1] = sum_odd;
          if (last_tap_i)
            out_q.push_back('{data: {requant_nibble(sum_odd), requant_nibble(sum_even)},
                              pair: channel_pair_i});
        end
      end
    end
    pending_o = out_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the depthwise_conv_u4_mac_requant testbench: reset, register setup, directed
// taps and randomized conv windows with random pacing; dwc_checker does the checking.
// Depends on dwc_pkg, the block and sim/dwc_checker.sv.
module tb;

  localparam int unsigned NPAIRS       = dwc_pkg::CHANNELS_DEF / 2;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CFG_EVERY    = 250;   // random requests between register phases
  localparam int unsigned SETTLE       = 8;     // margin for a last tap to clear MAC, MUL and OUT
  localparam int unsigned IDLE_LIMIT   = 500;   // cycles with no handshake at all
  localparam int unsigned MAX_GAP      = 16;
  localparam logic [dwc_pkg::ACC_W-1:0]  NIB_MASK   = (1 << dwc_pkg::NIB_W) - 1;
  localparam logic [dwc_pkg::ACC_W-1:0]  SHIFT_MASK = (1 << dwc_pkg::SHIFT_W) - 1;
  localparam logic [dwc_pkg::PAIR_W-1:0] LAST_PAIR  = dwc_pkg::PAIR_W'(NPAIRS - 1);

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          cmd = dwc_pkg::CMD_LOAD;
  logic [dwc_pkg::PAIR_W-1:0]    ch_pair = '0;
  logic [7:0]                    act_byte = '0;
  logic [7:0]                    wt_byte = '0;
  logic                          first_tap = 1'b0;
  logic                          last_tap = 1'b0;
  logic [dwc_pkg::ACC_W-1:0]     bias_even = '0;
  logic [dwc_pkg::ACC_W-1:0]     bias_odd = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dwc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dwc_pkg::ACC_W-1:0]     cfg_data = '0;
  logic                          out_valid;
  logic [7:0]                    out_byte;
  logic [dwc_pkg::PAIR_W-1:0]    out_pair;
  int unsigned                   fail_count;
  int unsigned                   pending;

  // stimulus bookkeeping: a tap may only read a bias or accumulator that was written
  bit [NPAIRS-1:0]      bias_ok = '0;
  bit [NPAIRS-1:0]      acc_ok = '0;
  int unsigned          items_sent = 0;
  int unsigned          gap_max = MAX_GAP;
  int unsigned          idle_cycles = 0;

  always #5 clk = ~clk;

  depthwise_conv_u4_mac_requant dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start              (start),
    .busy               (busy),
    .cmd_i              (cmd),
    .channel_pair_i     (ch_pair),
    .act_byte_i         (act_byte),
    .wt_byte_i          (wt_byte),
    .first_tap_i        (first_tap),
    .last_tap_i         (last_tap),
    .bias_even_i        (bias_even),
    .bias_odd_i         (bias_odd),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .out_valid_o        (out_valid),
    .out_byte_o         (out_byte),
    .out_channel_pair_o (out_pair)
  );

  dwc_checker scoreboard (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .channel_pair_i (ch_pair),
    .act_byte_i     (act_byte),
    .wt_byte_i      (wt_byte),
    .first_tap_i    (first_tap),
    .last_tap_i     (last_tap),
    .bias_even_i    (bias_even),
    .bias_odd_i     (bias_odd),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .out_valid_i    (out_valid),
    .out_byte_i     (out_byte),
    .out_pair_i     (out_pair),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: any request, register write or output strobe counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mixed bias values: mostly small so requant lands inside 0..15, some full range.
  function automatic logic [dwc_pkg::ACC_W-1:0] rand_bias();
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1023) - 512;
    endcase
  endfunction

  // One command request. Entered and left at a falling edge; start stays high
  // across back-to-back requests so it never gets two updates in one step.
  task automatic send_request(input logic c, input logic [dwc_pkg::PAIR_W-1:0] p,
                              input logic [7:0] a, input logic [7:0] w,
                              input logic f, input logic l,
                              input logic [dwc_pkg::ACC_W-1:0] be,
                              input logic [dwc_pkg::ACC_W-1:0] bo);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    ch_pair   <= p;
    act_byte  <= a;
    wt_byte   <= w;
    first_tap <= f;
    last_tap  <= l;
    bias_even <= be;
    bias_odd  <= bo;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    if (c == dwc_pkg::CMD_LOAD) bias_ok[p] = 1'b1;
    else acc_ok[p] = 1'b1;
  endtask

  // Load requests carry junk in the tap fields; the block must ignore them.
  task automatic load_bias(input logic [dwc_pkg::PAIR_W-1:0] p,
                           input logic [dwc_pkg::ACC_W-1:0] be,
                           input logic [dwc_pkg::ACC_W-1:0] bo);
    send_request(dwc_pkg::CMD_LOAD, p, 8'($urandom), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), be, bo);
  endtask

  // Tap requests carry junk bias fields.
  task automatic tap(input logic [dwc_pkg::PAIR_W-1:0] p, input logic [7:0] a,
                     input logic [7:0] w, input logic f, input logic l);
    send_request(dwc_pkg::CMD_TAP, p, a, w, f, l, $urandom, $urandom);
  endtask

  // Hold off new requests until every predicted output is out and the block is idle,
  // then give a tap without an output time to retire.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dwc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dwc_pkg::ACC_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Full register phase, only ever run with the engine drained. Narrow registers get
  // junk above their width; sometimes an unmapped index is written too.
  task automatic configure(input int azp, input int wzp, input int ozp,
                           input int mul, input int sh);
    logic [dwc_pkg::ACC_W-1:0] junk;
    drain();
    junk = $urandom;
    write_reg(dwc_pkg::REG_ACT_ZP, (junk & ~NIB_MASK) | (azp & NIB_MASK));
    junk = $urandom;
    write_reg(dwc_pkg::REG_WT_ZP, (junk & ~NIB_MASK) | (wzp & NIB_MASK));
    junk = $urandom;
    write_reg(dwc_pkg::REG_OUT_ZP, (junk & ~NIB_MASK) | (ozp & NIB_MASK));
    write_reg(dwc_pkg::REG_MULT, mul);
    junk = $urandom;
    write_reg(dwc_pkg::REG_SHIFT, (junk & ~SHIFT_MASK) | (sh & SHIFT_MASK));
    if ($urandom_range(0, 2) == 0)
      write_reg(dwc_pkg::CFG_IDX_W'($urandom_range(int'(dwc_pkg::REG_SHIFT) + 1,
                                                   (1 << dwc_pkg::CFG_IDX_W) - 1)),
                $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      // anything goes: mostly saturated outputs, exercises every register bit
      0: configure($urandom, $urandom, $urandom, $urandom, $urandom);
      // typical int4 setting: Q31 multiplier from one quarter up to one, small right shift
      1: configure($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(32'h2000_0000, 32'h7FFF_FFFF), $urandom_range(0, 8));
      // left shift ahead of a small multiplier of either sign
      2: configure($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                   ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 1 << 26)),
                   -int'($urandom_range(1, 8)));
      // corners of every register
      default: begin
        case ($urandom_range(0, 4))
          0: configure(0, 15, $urandom_range(0, 1) * 15, 32'h8000_0000, -32);
          1: configure(15, 0, 0, 32'h7FFF_FFFF, 31);
          2: configure(15, 15, 15, 0, -31);
          3: configure(0, 0, 8, 1, 0);
          default: configure($urandom_range(0, 1) * 15, $urandom_range(0, 1) * 15,
                              $urandom_range(0, 1) * 15, -1, 1);
        endcase
      end
    endcase
  endtask

  // One conv window on a pair: first tap restarts from the bias, last tap emits.
  // With cut set the window never closes, so no output is produced.
  task automatic run_window(input logic [dwc_pkg::PAIR_W-1:0] p, input int unsigned taps,
                            input bit cut);
    logic [7:0] a;
    for (int unsigned k = 0; k < taps; k++) begin
      a = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom);  // zero = padded tap
      tap(p, a, 8'($urandom), k == 0, (k == taps - 1) && !cut);
    end
  endtask

  initial begin
    logic [dwc_pkg::PAIR_W-1:0] p;
    int unsigned                pick;
    int unsigned                goal;
    int unsigned                next_cfg;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // reset values written back explicitly: plain Q31 one-half, no shift
    configure(0, 0, 0, 32'h4000_0000, 0);
    load_bias(0, 0, 0);
    load_bias(LAST_PAIR, 32'h7FFF_FFFF, 32'h8000_0000);
    tap(0, 8'hFF, 8'hFF, 1'b1, 1'b1);                   // largest product, clamps high
    tap(LAST_PAIR, 8'h00, 8'h00, 1'b1, 1'b1);           // padded tap, bias extremes
    tap(LAST_PAIR, 8'hFF, 8'hFF, 1'b0, 1'b1);           // even accumulator wraps
    load_bias(7, 5, -5);
    tap(7, 8'h21, 8'h13, 1'b1, 1'b0);
    tap(7, 8'h00, 8'hFF, 1'b0, 1'b0);
    tap(7, 8'hF0, 8'h0F, 1'b0, 1'b1);

    // all offsets at max, most negative multiplier, left shift by the full word
    configure(15, 15, 15, 32'h8000_0000, -32);
    tap(0, 8'h0F, 8'hF0, 1'b1, 1'b1);
    tap(7, 8'hA5, 8'h5A, 1'b0, 1'b1);

    // largest multiplier with the largest right shift
    configure(8, 3, 7, 32'h7FFF_FFFF, 31);
    tap(LAST_PAIR, 8'hFF, 8'h00, 1'b1, 1'b1);
    tap(0, 8'h3C, 8'hC3, 1'b1, 1'b0);                   // window left open ...
    tap(0, 8'h81, 8'h18, 1'b0, 1'b1);                   // ... and closed

    // left shift that pushes the bias into the sign bit
    configure(0, 0, 0, 32'h7FFF_FFFF, -1);
    load_bias(3, 32'h4000_0000, 32'hC000_0000);
    tap(3, 8'h00, 8'h00, 1'b1, 1'b1);

    // mid-scale offsets, round-to-floor on the right shift
    configure(8, 8, 8, 32'h4000_0000, 2);
    load_bias(12, -7, 9);
    tap(12, 8'h9E, 8'h71, 1'b1, 1'b0);
    tap(12, 8'h4B, 8'hD2, 1'b0, 1'b1);

    // ---- random part ----
    goal     = items_sent + RANDOM_ITEMS;
    next_cfg = items_sent;
    while (items_sent < goal) begin
      if (items_sent >= next_cfg) begin
        random_config();
        next_cfg = items_sent + CFG_EVERY;
      end
      // pacing per window: some back-to-back stretches, mostly random gaps
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      p    = dwc_pkg::PAIR_W'($urandom_range(0, NPAIRS - 1));
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        drain();                                        // sender waits for every output
      end else if (pick <= 2) begin
        // noise: stray bias reload, or a lone tap continuing whatever was left
        if ($urandom_range(0, 1) && acc_ok[p]) tap(p, 8'($urandom), 8'($urandom), 1'b0,
                                                   1'($urandom_range(0, 1)));
        else load_bias(p, rand_bias(), rand_bias());
      end else begin
        if (!bias_ok[p] || $urandom_range(0, 3) == 0) load_bias(p, rand_bias(), rand_bias());
        run_window(p, $urandom_range(1, 9), $urandom_range(0, 7) == 0);
      end
    end

    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dwc_pkg.sv
design/dwc_lane.sv
design/depthwise_conv_u4_mac_requant.sv
sim/dwc_checker.sv
sim/tb.sv
